// ===== design/tlvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types, codes and helper functions for the TLV container parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_BODY    = 3'd4,
        PH_ERROR   = 3'd5
    } tlvp_phase_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_TRUNCATED   = 3'd3;
    localparam logic [2:0] ST_BAD_CRC     = 3'd4;

    localparam logic [2:0] ROLE_HEADER = 3'd0;
    localparam logic [2:0] ROLE_TYPE   = 3'd1;
    localparam logic [2:0] ROLE_LENGTH = 3'd2;
    localparam logic [2:0] ROLE_BODY   = 3'd3;
    localparam logic [2:0] ROLE_ERROR  = 3'd4;

    localparam logic [3:0]  MAGIC_LEN      = 4'd4;
    localparam logic [3:0]  VERSION_POS    = 4'd4;
    localparam logic [3:0]  FEATURE_POS    = 4'd5;
    localparam logic [3:0]  CRC_FIRST_POS  = 4'd6;
    localparam logic [3:0]  CRC_LAST_POS   = 4'd9;
    localparam logic [7:0]  VERSION_1      = 8'd1;
    localparam logic [7:0]  VERSION_2      = 8'd2;
    localparam int          FEATURE_CRC    = 0;
    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;

    // classified byte handed from the front to the back
    typedef struct packed {
        logic [2:0]  role;
        logic [7:0]  data;
        logic [7:0]  kind;
        logic [15:0] size;
        logic [15:0] index;
        logic        blk_end;
        logic [1:0]  version;
        logic [7:0]  features;
        logic [2:0]  status;
        logic        last;
        logic        crc_zero;
        logic        crc_check;
        logic [31:0] expected;
    } tlvp_rec_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h73;
            2'd1:    m = 8'h6B;
            2'd2:    m = 8'h79;
            default: m = 8'h62;
        endcase
        return m;
    endfunction

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== design/tlv_container_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tlv_container_stream_parser
// Byte-stream parser for a tagged block container with optional CRC-32 check.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_ready is high and returns one tagged
// result per byte, in order. Each record is registered in the two-entry queue
// and then loaded into the output register once it is empty or being read.
// Throughput is one byte per clock while out_ready holds, set by the byte-wide
// CRC-32 update in the back end and the two-entry queue between the front end
// and the output stage. Errors are sticky until the byte marked last; the
// status on that byte is the file verdict and the parser then starts over for
// the next file. No reset sweep is needed.
module tlv_container_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_role,
    output logic [7:0]  byte_echo,
    output logic [7:0]  block_kind,
    output logic [15:0] block_size,
    output logic [15:0] body_index,
    output logic        block_end,
    output logic [1:0]  format_version,
    output logic [7:0]  feature_flags,
    output logic [2:0]  status,
    output logic        file_done
);
    import tlvp_pkg::*;

    tlvp_rec_t front_rec;
    tlvp_rec_t q_rec;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    logic      take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    tlvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .rec       (front_rec)
    );

    tlvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_rec  (front_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_rec   (q_rec)
    );

    tlvp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rec_valid      (q_valid),
        .rec            (q_rec),
        .rec_pop        (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_role      (byte_role),
        .byte_echo      (byte_echo),
        .block_kind     (block_kind),
        .block_size     (block_size),
        .body_index     (body_index),
        .block_end      (block_end),
        .format_version (format_version),
        .feature_flags  (feature_flags),
        .status         (status),
        .file_done      (file_done)
    );

endmodule

// ===== design/tlvp_front.sv =====
// ----------------------------------------------------------------------------
// tlvp_front
// Header and block parser: tags each byte and tracks the container state.
// ----------------------------------------------------------------------------
module tlvp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output tlvp_pkg::tlvp_rec_t rec
);
    import tlvp_pkg::*;

    tlvp_phase_t phase_reg, phase_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [1:0]  version_reg, version_next;
    logic [7:0]  features_reg, features_next;
    logic [31:0] exp_reg, exp_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] bcount_reg, bcount_next;
    logic [2:0]  error_reg, error_next;
    logic [15:0] bcount_inc;
    logic [15:0] size_hi;
    logic [1:0]  crc_idx;

    assign bcount_inc = bcount_reg + 16'd1;
    assign size_hi    = {data_byte, size_reg[7:0]};
    assign crc_idx    = hcount_reg[1:0] + 2'd2;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (hcount_reg < MAGIC_LEN) begin
                    if (data_byte != magic_byte(hcount_reg[1:0])) phase_next = PH_ERROR;
                end else if (hcount_reg == VERSION_POS) begin
                    if (data_byte == VERSION_1)      phase_next = PH_TYPE;
                    else if (data_byte != VERSION_2) phase_next = PH_ERROR;
                end else if (hcount_reg == FEATURE_POS) begin
                    if (!data_byte[FEATURE_CRC]) phase_next = PH_TYPE;
                end else if (hcount_reg <= CRC_LAST_POS) begin
                    if (hcount_reg == CRC_LAST_POS) phase_next = PH_TYPE;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:   phase_next = PH_LEN_LO;
            PH_LEN_LO: phase_next = PH_LEN_HI;
            PH_LEN_HI: phase_next = (size_hi == 16'd0) ? PH_TYPE : PH_BODY;
            PH_BODY:   phase_next = (bcount_inc == size_reg) ? PH_TYPE : PH_BODY;
            PH_ERROR:  phase_next = PH_ERROR;
            default:   phase_next = PH_ERROR;
        endcase
    end

    // datapath and tagged record
    always_comb
    begin
        hcount_next   = hcount_reg;
        version_next  = version_reg;
        features_next = features_reg;
        exp_next      = exp_reg;
        kind_next     = kind_reg;
        size_next     = size_reg;
        bcount_next   = bcount_reg;
        error_next    = error_reg;

        rec           = '0;
        rec.role      = ROLE_ERROR;
        rec.data      = data_byte;
        rec.last      = last_byte;
        rec.crc_zero  = (phase_reg == PH_HEADER) && (hcount_reg >= CRC_FIRST_POS)
                        && (hcount_reg <= CRC_LAST_POS);

        unique case (phase_reg)
            PH_HEADER:
            begin
                rec.role    = ROLE_HEADER;
                hcount_next = hcount_reg + 4'd1;
                if (hcount_reg < MAGIC_LEN) begin
                    if (data_byte != magic_byte(hcount_reg[1:0])) error_next = ST_BAD_MAGIC;
                end else if (hcount_reg == VERSION_POS) begin
                    if (data_byte == VERSION_1 || data_byte == VERSION_2)
                        version_next = data_byte[1:0];
                    else
                        error_next = ST_BAD_VERSION;
                end else if (hcount_reg == FEATURE_POS) begin
                    features_next = data_byte;
                end else if (hcount_reg <= CRC_LAST_POS) begin
                    // little-endian: header bytes 6..9 map to CRC bytes 0..3
                    case (crc_idx)
                        2'd0:    exp_next[7:0]   = exp_reg[7:0]   | data_byte;
                        2'd1:    exp_next[15:8]  = exp_reg[15:8]  | data_byte;
                        2'd2:    exp_next[23:16] = exp_reg[23:16] | data_byte;
                        default: exp_next[31:24] = exp_reg[31:24] | data_byte;
                    endcase
                end
            end
            PH_TYPE:
            begin
                rec.role    = ROLE_TYPE;
                kind_next   = data_byte;
                size_next   = 16'd0;
                bcount_next = 16'd0;
            end
            PH_LEN_LO:
            begin
                rec.role  = ROLE_LENGTH;
                size_next = {8'd0, data_byte};
            end
            PH_LEN_HI:
            begin
                rec.role    = ROLE_LENGTH;
                size_next   = size_hi;
                rec.size    = size_hi;
                rec.blk_end = (size_hi == 16'd0);
            end
            PH_BODY:
            begin
                rec.role    = ROLE_BODY;
                rec.size    = size_reg;
                rec.index   = bcount_reg;
                bcount_next = bcount_inc;
                rec.blk_end = (bcount_inc == size_reg);
            end
            PH_ERROR: rec.role = ROLE_ERROR;
            default:  rec.role = ROLE_ERROR;
        endcase

        rec.kind     = kind_next;
        rec.version  = version_next;
        rec.features = features_next;
        rec.expected = exp_next;
        rec.status   = error_next;

        // end-of-file verdict; CRC comparison is finished in the back end
        if (last_byte && error_next == ST_OK) begin
            if (phase_next == PH_HEADER) begin
                rec.status = ST_TRUNCATED;
            end else begin
                rec.crc_check = features_next[FEATURE_CRC];
                if (phase_next != PH_TYPE) rec.status = ST_TRUNCATED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_HEADER;
            hcount_reg   <= 4'd0;
            version_reg  <= 2'd0;
            features_reg <= 8'd0;
            exp_reg      <= 32'd0;
            kind_reg     <= 8'd0;
            size_reg     <= 16'd0;
            bcount_reg   <= 16'd0;
            error_reg    <= ST_OK;
        end else if (take) begin
            if (last_byte) begin
                phase_reg    <= PH_HEADER;
                hcount_reg   <= 4'd0;
                version_reg  <= 2'd0;
                features_reg <= 8'd0;
                exp_reg      <= 32'd0;
                kind_reg     <= 8'd0;
                size_reg     <= 16'd0;
                bcount_reg   <= 16'd0;
                error_reg    <= ST_OK;
            end else begin
                phase_reg    <= phase_next;
                hcount_reg   <= hcount_next;
                version_reg  <= version_next;
                features_reg <= features_next;
                exp_reg      <= exp_next;
                kind_reg     <= kind_next;
                size_reg     <= size_next;
                bcount_reg   <= bcount_next;
                error_reg    <= error_next;
            end
        end
    end

endmodule

// ===== design/tlvp_queue.sv =====
// ----------------------------------------------------------------------------
// tlvp_queue
// Two-entry queue of tagged byte records between front and back end.
// ----------------------------------------------------------------------------
module tlvp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tlvp_pkg::tlvp_rec_t push_rec,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output tlvp_pkg::tlvp_rec_t pop_rec
);
    import tlvp_pkg::*;

    tlvp_rec_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_rec   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/tlvp_back.sv =====
// ----------------------------------------------------------------------------
// tlvp_back
// Running CRC-32, checksum verdict and the output register.
// ----------------------------------------------------------------------------
module tlvp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rec_valid,
    input  tlvp_pkg::tlvp_rec_t rec,
    output logic                rec_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          byte_role,
    output logic [7:0]          byte_echo,
    output logic [7:0]          block_kind,
    output logic [15:0]         block_size,
    output logic [15:0]         body_index,
    output logic                block_end,
    output logic [1:0]          format_version,
    output logic [7:0]          feature_flags,
    output logic [2:0]          status,
    output logic                file_done
);
    import tlvp_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [2:0]  status_next;
    logic        out_valid_reg;

    assign rec_pop   = rec_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign crc_next  = crc_byte(crc_reg, rec.crc_zero ? 8'd0 : rec.data);

    always_comb
    begin
        status_next = rec.status;
        if (rec.crc_check && ((crc_next ^ CRC_INIT) != rec.expected))
            status_next = ST_BAD_CRC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            if (rec_pop) crc_reg <= rec.last ? CRC_INIT : crc_next;
            if (rec_pop)        out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop) begin
            byte_role      <= rec.role;
            byte_echo      <= rec.data;
            block_kind     <= rec.kind;
            block_size     <= rec.size;
            body_index     <= rec.index;
            block_end      <= rec.blk_end;
            format_version <= rec.version;
            feature_flags  <= rec.features;
            status         <= status_next;
            file_done      <= rec.last;
        end
    end

endmodule
